[design/pal_line_sync_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// PAL line sync sequencer assertion macros
// Concurrent assertion wrappers on the block clock. Under synthesis the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef PAL_LINE_SYNC_SEQUENCER_ASSERT_SVH
`define PAL_LINE_SYNC_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every edge outside reset.
`define PLSS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("plss assertion failed");

// Checked on every edge, reset included.
`define PLSS_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("plss assertion failed");

`else

`define PLSS_ASSERT(name, prop)
`define PLSS_ASSERT_ALWAYS(name, prop)

`endif

`endif

[design/plss_pkg.sv]
// ----------------------------------------------------------------------------
// PAL line sync sequencer package
// Phase codes, register indexes, reset values and the result layout.
// ----------------------------------------------------------------------------
package plss_pkg;

   // Default sizing of the line counters and the phase countdown.
   localparam int LINE_BITS_DEF = 9;
   localparam int TIME_BITS_DEF = 7;

   // Fixed widths of the register fields.
   localparam int CFG_LEN_W  = 7;
   localparam int CFG_SP_W   = 5;
   localparam int CFG_LP_W   = 6;
   localparam int CFG_PORCH_W = 5;
   localparam int CFG_LINE_W = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LENGTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PULSE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PULSE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_PORCH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_PORCH        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ACTIVE_LINE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LINES      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES_PER_FRAME   = 3'd7;

   // Register reset values (standard 625/2 line PAL timing at 64 units).
   localparam int LINE_LENGTH_RST       = 64;
   localparam int SHORT_PULSE_RST       = 5;
   localparam int LONG_PULSE_RST        = 27;
   localparam int FRONT_PORCH_RST       = 10;
   localparam int BACK_PORCH_RST        = 2;
   localparam int FIRST_ACTIVE_LINE_RST = 32;
   localparam int ACTIVE_LINES_RST      = 256;
   localparam int LINES_PER_FRAME_RST   = 312;

   // Vertical sync region: the last VS_TAIL lines and lines below VS_HEAD.
   localparam int VS_TAIL  = 3;
   localparam int VS_HEAD  = 5;
   // Lines with two broad pulses, and the one line with broad then short.
   localparam int VS_BROAD = 2;

   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_SYNC1  = 3'd1,
      PH_GAP1   = 3'd2,
      PH_SYNC2  = 3'd3,
      PH_FRONT  = 3'd4,
      PH_WINDOW = 3'd5
   } phase_type;

   // Result layout, declared from the top bit down; sync_active is bit 0.
   typedef struct packed {
      logic                  pad;
      logic                  frame_start;
      logic [CFG_LINE_W-1:0] fetch_row;
      logic                  fetch_request;
      logic                  vsync_region;
      logic [CFG_LINE_W-1:0] line_number;
      logic                  video_window;
      logic                  sync_active;
   } rsp_type;

endpackage

[design/pal_line_sync_sequencer.sv]
// ----------------------------------------------------------------------------
// PAL line sync sequencer
// Steps a non-interlaced PAL composite sync pattern one time unit per
// request with the advance bit set and reports sync, video window, line and row fetch status.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Handshake
//  req_*     in         tdata[0] advance                         tvalid/tready
//  rsp_*     out        tdata[22:0] status, see rsp_tdata below  tvalid/tready
//  csr_*     in         csr_index, csr_wdata                     csr_wr_en
//
//  The timing state is updated as each request is accepted and the
//  status goes into a two-entry output buffer, so one request per cycle
//  is sustained while the consumer takes results and no remainder calculation runs.
//  Reset is synchronous; it reloads the registers with their defaults.
//  Writing active_lines starts a remainder calculation of the current row
//  number, during which req_tready is low.
//  req_tready also drops when both output entries hold unread results.
//
module pal_line_sync_sequencer
   import plss_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] advance, [7:1] zero
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] sync_active, [1] video_window, [10:2] line_number,
   // [11] vsync_region, [12] fetch_request, [21:13] fetch_row,
   // [22] frame_start, [23] zero
   output logic [23:0]           rsp_tdata,
   // Configuration write port.
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "pal_line_sync_sequencer_assert.svh"

   // Compare width that covers both the line counter and the line registers.
   localparam int CW = ((LINE_BITS > CFG_LINE_W) ? LINE_BITS : CFG_LINE_W) + 2;
   // Signed width for phase lengths before clamping.
   localparam int DW = TIME_BITS + 3;
   localparam int TMAX_INT = (1 << TIME_BITS) - 1;
   localparam int CD_RST_INT = (LINE_LENGTH_RST > TMAX_INT) ? TMAX_INT : LINE_LENGTH_RST;
   localparam logic [TIME_BITS-1:0] CD_RST = TIME_BITS'(CD_RST_INT);
   localparam int CNT_W = $clog2(LINE_BITS + 1);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [CFG_LEN_W-1:0]   line_length_ff;
   logic [CFG_SP_W-1:0]    short_pulse_ff;
   logic [CFG_LP_W-1:0]    long_pulse_ff;
   logic [CFG_PORCH_W-1:0] front_porch_ff;
   logic [CFG_PORCH_W-1:0] back_porch_ff;
   logic [CFG_LINE_W-1:0]  first_active_ff;
   logic [CFG_LINE_W-1:0]  active_lines_ff;
   logic [CFG_LINE_W-1:0]  lines_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff  <= CFG_LEN_W'(LINE_LENGTH_RST);
         short_pulse_ff  <= CFG_SP_W'(SHORT_PULSE_RST);
         long_pulse_ff   <= CFG_LP_W'(LONG_PULSE_RST);
         front_porch_ff  <= CFG_PORCH_W'(FRONT_PORCH_RST);
         back_porch_ff   <= CFG_PORCH_W'(BACK_PORCH_RST);
         first_active_ff <= CFG_LINE_W'(FIRST_ACTIVE_LINE_RST);
         active_lines_ff <= CFG_LINE_W'(ACTIVE_LINES_RST);
         lines_frame_ff  <= CFG_LINE_W'(LINES_PER_FRAME_RST);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LINE_LENGTH:       line_length_ff  <= csr_wdata[CFG_LEN_W-1:0];
            CSR_SHORT_PULSE:       short_pulse_ff  <= csr_wdata[CFG_SP_W-1:0];
            CSR_LONG_PULSE:        long_pulse_ff   <= csr_wdata[CFG_LP_W-1:0];
            CSR_FRONT_PORCH:       front_porch_ff  <= csr_wdata[CFG_PORCH_W-1:0];
            CSR_BACK_PORCH:        back_porch_ff   <= csr_wdata[CFG_PORCH_W-1:0];
            CSR_FIRST_ACTIVE_LINE: first_active_ff <= csr_wdata[CFG_LINE_W-1:0];
            CSR_ACTIVE_LINES:      active_lines_ff <= csr_wdata[CFG_LINE_W-1:0];
            CSR_LINES_PER_FRAME:   lines_frame_ff  <= csr_wdata[CFG_LINE_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Helper functions.
   // ------------------------------------------------------------------

   // A phase lasts at least one unit and saturates at the countdown range.
   function automatic logic [TIME_BITS-1:0] clamp_len(input logic signed [DW-1:0] d);
      logic [TIME_BITS-1:0] res;
      begin
         if (d[DW-1] || (d == '0)) begin
            res = TIME_BITS'(1);
         end else if (d > $signed({3'b000, TIME_BITS'(TMAX_INT)})) begin
            res = TIME_BITS'(TMAX_INT);
         end else begin
            res = d[TIME_BITS-1:0];
         end
         return res;
      end
   endfunction

   // Line lies in the last VS_TAIL lines of the frame or below VS_HEAD.
   // Written as ln + 3 >= lpf so that very short frames need no special arm.
   function automatic logic vs_of(input logic [LINE_BITS-1:0] ln,
                                  input logic [CFG_LINE_W-1:0] lpf);
      logic [CW-1:0] l;
      logic [CW-1:0] p;
      begin
         l = CW'(ln);
         p = CW'(lpf);
         return ((l + CW'(VS_TAIL)) >= p) || (l < CW'(VS_HEAD));
      end
   endfunction

   // ------------------------------------------------------------------
   // Timing state.
   // ------------------------------------------------------------------
   phase_type             phase_ff, phase_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic [LINE_BITS-1:0]  row_ff, row_in;
   logic [CFG_LINE_W-1:0] row_mod_ff, row_mod_in;   // row_ff modulo active lines
   logic [TIME_BITS-1:0]  count_ff, count_in;
   logic [CFG_LP_W-1:0]   first_half_ff, first_half_in;
   logic [CFG_LP_W-1:0]   second_half_ff, second_half_in;

   // Remainder unit used after active_lines changes.
   logic                  div_busy_ff;
   logic [CNT_W-1:0]      div_cnt_ff;
   logic [LINE_BITS-1:0]  div_q_ff;
   logic [CFG_LINE_W-1:0] div_rem_ff, div_rem_in;
   logic [CFG_LINE_W:0]   div_shift;

   // Output buffer.
   rsp_type head_ff, skid_ff, result;
   logic    head_valid_ff, skid_valid_ff;

   logic                  accept, pop, advance;
   logic                  load, fetch, fstart, vs_now;
   logic signed [DW-1:0]  dur, half;
   logic [LINE_BITS-1:0]  line_inc;
   logic [CFG_LINE_W:0]   mod_inc;
   logic                  in_video;
   logic [CW-1:0]         line_cw, first_cw;

   assign req_tready = !div_busy_ff && !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = head_valid_ff && rsp_tready;
   assign advance    = req_tdata[0];

   assign line_cw  = CW'(line_ff);
   assign first_cw = CW'(first_active_ff);
   assign in_video = (line_cw >= first_cw) && (line_cw < first_cw + CW'(active_lines_ff));
   assign vs_now   = vs_of(line_ff, lines_frame_ff);
   assign half     = DW'(line_length_ff >> 1);
   assign line_inc = line_ff + LINE_BITS'(1);
   assign mod_inc  = {1'b0, row_mod_ff} + (CFG_LINE_W + 1)'(1);

   // Next state for one time unit. A phase change loads the countdown.
   always_comb begin
      phase_in       = phase_ff;
      line_in        = line_ff;
      row_in         = row_ff;
      row_mod_in     = row_mod_ff;
      count_in       = count_ff;
      first_half_in  = first_half_ff;
      second_half_in = second_half_ff;
      dur            = DW'(1);
      load           = 1'b0;
      fetch          = 1'b0;
      fstart         = 1'b0;
      if (advance) begin
         if (count_ff > TIME_BITS'(1)) begin
            count_in = count_ff - TIME_BITS'(1);
         end else begin
            load = 1'b1;
            case (phase_ff)
               PH_SYNC1: begin
                  if (vs_now) begin
                     dur      = half - DW'(first_half_ff);
                     phase_in = PH_GAP1;
                  end else if (in_video) begin
                     dur      = DW'(front_porch_ff);
                     phase_in = PH_FRONT;
                  end else begin
                     dur      = DW'(line_length_ff) - DW'(short_pulse_ff);
                     phase_in = PH_WAIT;
                  end
               end
               PH_GAP1: begin
                  dur      = DW'(second_half_ff);
                  phase_in = PH_SYNC2;
               end
               PH_SYNC2: begin
                  dur      = half - DW'(second_half_ff);
                  phase_in = PH_WAIT;
               end
               PH_FRONT: begin
                  dur = DW'(line_length_ff) - (DW'(short_pulse_ff) + DW'(front_porch_ff)
                        + DW'(back_porch_ff));
                  phase_in = PH_WINDOW;
                  row_in   = row_ff + LINE_BITS'(1);
                  // Besides the restart at the end of the frame, the row counter only returns to zero by wrapping.
                  if (row_in == '0) begin
                     row_mod_in = '0;
                  end else if (mod_inc == {1'b0, active_lines_ff}) begin
                     row_mod_in = '0;
                  end else begin
                     row_mod_in = mod_inc[CFG_LINE_W-1:0];
                  end
                  fetch = 1'b1;
               end
               PH_WINDOW: begin
                  dur      = DW'(back_porch_ff);
                  phase_in = PH_WAIT;
               end
               default: begin
                  // End of the line: step the line counter, start the sync pulse.
                  if (CW'(line_inc) >= CW'(lines_frame_ff)) begin
                     line_in    = '0;
                     row_in     = '0;
                     row_mod_in = '0;
                     fstart     = 1'b1;
                  end else begin
                     line_in = line_inc;
                  end
                  if (vs_of(line_in, lines_frame_ff)) begin
                     if (CW'(line_in) < CW'(VS_BROAD)) begin
                        first_half_in  = long_pulse_ff;
                        second_half_in = long_pulse_ff;
                     end else if (CW'(line_in) == CW'(VS_BROAD)) begin
                        first_half_in  = long_pulse_ff;
                        second_half_in = CFG_LP_W'(short_pulse_ff);
                     end else begin
                        first_half_in  = CFG_LP_W'(short_pulse_ff);
                        second_half_in = CFG_LP_W'(short_pulse_ff);
                     end
                     dur = DW'(first_half_in);
                  end else begin
                     dur = DW'(short_pulse_ff);
                  end
                  phase_in = PH_SYNC1;
               end
            endcase
         end
      end
      if (load) begin
         count_in = clamp_len(dur);
      end
   end

   // Result word, reflecting the state after this unit.
   always_comb begin
      result               = '0;
      result.sync_active   = (phase_in == PH_SYNC1) || (phase_in == PH_SYNC2);
      result.video_window  = (phase_in == PH_WINDOW);
      result.line_number   = CFG_LINE_W'(line_in);
      result.vsync_region  = vs_of(line_in, lines_frame_ff);
      result.fetch_request = fetch;
      result.fetch_row     = (fetch && (active_lines_ff != '0)) ? row_mod_in : '0;
      result.frame_start   = fstart;
   end

   // Restoring remainder, one dividend bit per cycle, most significant first.
   assign div_shift = {div_rem_ff, div_q_ff[LINE_BITS-1]};
   always_comb begin
      if (div_shift >= {1'b0, active_lines_ff}) begin
         div_rem_in = CFG_LINE_W'(div_shift - {1'b0, active_lines_ff});
      end else begin
         div_rem_in = div_shift[CFG_LINE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (csr_wr_en && (csr_index == CSR_ACTIVE_LINES)) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= CNT_W'(LINE_BITS);
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - CNT_W'(1);
         if (div_cnt_ff == CNT_W'(1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (csr_wr_en && (csr_index == CSR_ACTIVE_LINES)) begin
         div_rem_ff <= '0;
         div_q_ff   <= row_ff;
      end else if (div_busy_ff) begin
         div_rem_ff <= div_rem_in;
         div_q_ff   <= {div_q_ff[LINE_BITS-2:0], 1'b0};
      end
   end

   // Timing state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT;
         line_ff        <= '0;
         row_ff         <= '0;
         row_mod_ff     <= '0;
         count_ff       <= CD_RST;
         first_half_ff  <= '0;
         second_half_ff <= '0;
      end else if (div_busy_ff) begin
         if (div_cnt_ff == CNT_W'(1)) begin
            row_mod_ff <= div_rem_in;
         end
      end else if (accept) begin
         phase_ff       <= phase_in;
         line_ff        <= line_in;
         row_ff         <= row_in;
         row_mod_ff     <= row_mod_in;
         count_ff       <= count_in;
         first_half_ff  <= first_half_in;
         second_half_ff <= second_half_in;
      end
   end

   // Two-entry output buffer: the head drives the port, the skid entry
   // catches a result made while the head is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_valid_ff <= 1'b1;
            skid_valid_ff <= accept;
         end else begin
            head_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
            skid_ff <= result;
         end else begin
            head_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = head_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `PLSS_ASSERT_ALWAYS(a_skid_behind_head, skid_valid_ff |-> head_valid_ff)
   `PLSS_ASSERT(a_fetch_in_window, (rsp_tvalid && head_ff.fetch_request) |-> head_ff.video_window)
   `PLSS_ASSERT(a_frame_start_line0, (rsp_tvalid && head_ff.frame_start) |-> (head_ff.line_number == '0))
   `PLSS_ASSERT(a_rows_recalc, (csr_wr_en && (csr_index == CSR_ACTIVE_LINES)) |=> (div_busy_ff && !req_tready))

endmodule
